// File: sv/ffp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared codes and constants for the fundamental matrix block.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int DET_SHIFT = 20;
  localparam int OUT_W     = 48;
  localparam int ELEM_IN_W = 16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef logic [1:0] idx2_t;

  // Column pairs of the 2x2 minors: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
  function automatic idx2_t pair_col_a(input logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd2: pair_col_a = 2'd0;
      3'd3, 3'd4:       pair_col_a = 2'd1;
      default:          pair_col_a = 2'd2;
    endcase
  endfunction

  function automatic idx2_t pair_col_b(input logic [2:0] p);
    case (p)
      3'd0:       pair_col_b = 2'd1;
      3'd1, 3'd3: pair_col_b = 2'd2;
      default:    pair_col_b = 2'd3;
    endcase
  endfunction

endpackage

// File: sv/ffp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_in_if / ffp_out_if
// Valid/ready channels for commands and fundamental matrix entries.
// ----------------------------------------------------------------------------
interface ffp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        which_matrix;
  logic [1:0]  elem_row;
  logic [1:0]  elem_col;
  logic signed [15:0] elem_value;
  modport source (output valid, opcode, which_matrix, elem_row, elem_col, elem_value,
                  input ready);
  modport sink (input valid, opcode, which_matrix, elem_row, elem_col, elem_value,
                output ready);
endinterface

interface ffp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic signed [47:0] out_value;
  logic        saturated;
  logic        last;
  modport source (output valid, out_row, out_col, out_value, saturated, last,
                  input ready);
  modport sink (input valid, out_row, out_col, out_value, saturated, last,
                output ready);
endinterface

// File: sv/ffp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry when enabled, and read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/fundamental_from_projections.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fundamental_from_projections
// Builds the 3x3 fundamental matrix from two stored 3x4 projections.
// ----------------------------------------------------------------------------
// A load beat writes one element into the 24-entry store unless its row is 3.
// A compute beat emits nine entries in row-major order, the ninth marked last.
// Each entry is a 4x4 determinant: 16 store reads through the one port, twelve
// 2x2 minors, six minor products, each split in two halves, summed into a wide
// accumulator, then a shift and saturate that hands the beat to the output
// register, waiting there while the previous beat has not been taken.
// The block takes no input beat while a compute is in progress.
module fundamental_from_projections
  import ffp_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ffp_in_if.sink     in_ch,
  ffp_out_if.source  out_ch
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int MW = 2 * EW + 1;
  localparam int H  = MW / 2;
  localparam int AW = 4 * EW + 4;
  localparam int PW = MW + H + 2;
  localparam int SW = (AW - DET_SHIFT > OUT_W) ? AW - DET_SHIFT : OUT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MINOR = 3'd2;
  localparam logic [2:0] ST_TERM  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;

  logic signed [EW-1:0] e_r [16];
  logic signed [MW-1:0] mt_r [6];
  logic signed [MW-1:0] mb_r [6];
  logic signed [PW-1:0] prod_r;
  logic                 prod_hi_r;
  logic signed [AW-1:0] acc_r;

  logic        out_valid_r;
  logic [1:0]  out_row_r, out_col_r;
  logic signed [OUT_W-1:0] out_value_r;
  logic        out_sat_r, out_last_r;

  // store port
  logic          ram_we;
  logic [4:0]    ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   elem_u;

  ffp_ram #(.WIDTH(EW), .DEPTH(24)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic in_fire, out_free;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // read address of the determinant rows: t0 t1 from P1, b0 b1 from P2
  logic [1:0] rd_base;
  logic [2:0] rd_sum;
  logic [1:0] rd_row;
  logic [3:0] rd_k;
  assign rd_k    = cnt_r[3:0];
  assign rd_base = rd_k[3] ? i_r : j_r;
  assign rd_sum  = 3'(rd_base) + 3'd1 + 3'(rd_k[2]);
  assign rd_row  = (rd_sum >= 3'd3) ? 2'(rd_sum - 3'd3) : rd_sum[1:0];

  assign elem_u    = 32'(unsigned'(in_ch.elem_value));
  assign ram_wdata = elem_u[EW-1:0];
  assign ram_we    = in_fire && (in_ch.opcode == OP_LOAD) && (in_ch.elem_row != 2'd3);
  always_comb begin
    if (state_r == ST_IDLE) begin
      ram_addr = (in_ch.which_matrix ? 5'd12 : 5'd0) + 5'({in_ch.elem_row, in_ch.elem_col});
    end else begin
      ram_addr = (rd_k[3] ? 5'd12 : 5'd0) + 5'({rd_row, rd_k[1:0]});
    end
  end

  // 2x2 minor of the current step
  logic [2:0] mp;
  logic [3:0] r0b;
  idx2_t      ca, cb;
  logic signed [2*EW-1:0] p1, p2;
  logic signed [MW-1:0]   minor_w;
  always_comb begin
    if (cnt_r < 5'd6) begin
      mp  = cnt_r[2:0];
      r0b = 4'd0;
    end else begin
      mp  = 3'(5'd11 - cnt_r);
      r0b = 4'd8;
    end
    ca = pair_col_a(mp);
    cb = pair_col_b(mp);
    p1 = e_r[r0b + 4'(ca)] * e_r[r0b + 4'd4 + 4'(cb)];
    p2 = e_r[r0b + 4'(cb)] * e_r[r0b + 4'd4 + 4'(ca)];
    minor_w = MW'(p1) - MW'(p2);
  end

  // split product of the head minors, sign folded into the top minor
  logic [2:0] tp;
  logic signed [MW:0]  ta;
  logic signed [H:0]   tb;
  logic signed [PW-1:0] mul_w;
  logic signed [AW-1:0] add_w;
  always_comb begin
    tp = 3'(cnt_r >> 1);
    ta = (tp == 3'd1 || tp == 3'd4) ? -(MW + 1)'(mt_r[0]) : (MW + 1)'(mt_r[0]);
    if (cnt_r[0]) begin
      tb = (H + 1)'(mb_r[0] >>> H);
    end else begin
      tb = signed'({1'b0, mb_r[0][H-1:0]});
    end
    mul_w = PW'(ta) * PW'(tb);
    add_w = prod_hi_r ? (AW'(prod_r) <<< H) : AW'(prod_r);
  end

  // shift right by DET_SHIFT bits and clip to the signed 48-bit output range
  logic signed [SW+DET_SHIFT-1:0] acc_x;
  logic signed [SW-1:0]           sh;
  logic                           fits;
  assign acc_x = (SW + DET_SHIFT)'(acc_r);
  assign sh    = SW'(acc_x >>> DET_SHIFT);
  assign fits  = (&sh[SW-1:OUT_W-1]) || !(|sh[SW-1:OUT_W-1]);

  // sequence the nine determinants
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.opcode == OP_COMPUTE) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = 5'd0;
          i_nxt     = 2'd0;
          j_nxt     = 2'd0;
        end
      end
      ST_LOAD: begin
        if (cnt_r == 5'd16) begin
          state_nxt = ST_MINOR;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_MINOR: begin
        if (cnt_r == 5'd11) begin
          state_nxt = ST_TERM;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_TERM: begin
        if (cnt_r == 5'd12) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cnt_nxt = 5'd0;
          if (i_r == 2'd2 && j_r == 2'd2) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOAD;
            if (j_r == 2'd2) begin
              j_nxt = 2'd0;
              i_nxt = i_r + 2'd1;
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 5'd0;
      i_r     <= 2'd0;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && cnt_r != 5'd0) begin
      for (int k = 0; k < 15; k++) begin
        e_r[k] <= e_r[k+1];
      end
      e_r[15] <= signed'(ram_rdata);
    end
    if (state_r == ST_MINOR) begin
      if (cnt_r < 5'd6) begin
        for (int k = 0; k < 5; k++) begin
          mt_r[k] <= mt_r[k+1];
        end
        mt_r[5] <= minor_w;
      end else begin
        for (int k = 0; k < 5; k++) begin
          mb_r[k] <= mb_r[k+1];
        end
        mb_r[5] <= minor_w;
      end
    end
    if (state_r == ST_TERM) begin
      if (cnt_r < 5'd12) begin
        prod_r    <= mul_w;
        prod_hi_r <= cnt_r[0];
        if (cnt_r[0]) begin
          for (int k = 0; k < 5; k++) begin
            mt_r[k] <= mt_r[k+1];
            mb_r[k] <= mb_r[k+1];
          end
        end
      end
      if (cnt_r == 5'd0) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + add_w;
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_sat_r   <= !fits;
      out_last_r  <= (i_r == 2'd2 && j_r == 2'd2);
      if (fits) begin
        out_value_r <= sh[OUT_W-1:0];
      end else if (sh[SW-1]) begin
        out_value_r <= {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        out_value_r <= {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.saturated = out_sat_r;
  assign out_ch.last      = out_last_r;

`ifndef SYNTHESIS
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_row_r == 2'd2 && out_col_r == 2'd2)
    else $error("last beat not at entry (2,2)");
  a_term_after_minor: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_TERM) |-> $past(state_r) == ST_MINOR)
    else $error("product phase entered out of order");
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free && i_r == 2'd2 && j_r == 2'd2 |=> state_r == ST_IDLE)
    else $error("run did not end after ninth entry");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> !in_ch.ready && !ram_we)
    else $error("store written during compute");
`endif

endmodule

// File: tb/ffp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_checker
// Predicts fundamental matrix entries from observed load and compute beats
// and compares every output beat, field by field, in order.
// ----------------------------------------------------------------------------
module ffp_checker
  import ffp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ffp_in_if.sink    in_mon,
  ffp_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_entries
);

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [47:0] value;
    logic               sat;
    logic               last;
  } f_entry_t;

  logic signed [15:0] proj_store [0:23];
  f_entry_t           entry_q [$];

  assign pending_entries = entry_q.size();

  function automatic logic signed [47:0] minor2(input int ra, input int rb,
                                                input int ca, input int cb);
    return 48'(proj_store[ra*4+ca]) * 48'(proj_store[rb*4+cb])
         - 48'(proj_store[ra*4+cb]) * 48'(proj_store[rb*4+ca]);
  endfunction

  // Laplace expansion over the top two rows; exact in 128 bits.
  function automatic logic signed [127:0] det4(input int t0, input int t1,
                                               input int b0, input int b1);
    logic signed [127:0] acc;
    acc = 0;
    acc += 128'(minor2(t0, t1, 0, 1)) * 128'(minor2(b0, b1, 2, 3));
    acc -= 128'(minor2(t0, t1, 0, 2)) * 128'(minor2(b0, b1, 1, 3));
    acc += 128'(minor2(t0, t1, 0, 3)) * 128'(minor2(b0, b1, 1, 2));
    acc += 128'(minor2(t0, t1, 1, 2)) * 128'(minor2(b0, b1, 0, 3));
    acc -= 128'(minor2(t0, t1, 1, 3)) * 128'(minor2(b0, b1, 0, 2));
    acc += 128'(minor2(t0, t1, 2, 3)) * 128'(minor2(b0, b1, 0, 1));
    return acc;
  endfunction

  task automatic predict_fundamental();
    logic signed [127:0] d;
    f_entry_t e;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d = det4((j + 1) % 3, (j + 2) % 3, 3 + (i + 1) % 3, 3 + (i + 2) % 3);
        d = d >>> DET_SHIFT;
        e.row  = 2'(i);
        e.col  = 2'(j);
        e.last = (i == 2 && j == 2);
        e.sat  = 1'b0;
        e.value = d[47:0];
        if (d > 128'sh7FFF_FFFF_FFFF) begin
          e.value = 48'sh7FFF_FFFF_FFFF;
          e.sat   = 1'b1;
        end else if (d < -128'sh8000_0000_0000) begin
          e.value = 48'sh8000_0000_0000;
          e.sat   = 1'b1;
        end
        entry_q.push_back(e);
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Watch both channels at each edge.
  always @(posedge clk) begin
    f_entry_t want;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      if (in_mon.opcode == OP_COMPUTE) begin
        predict_fundamental();
      end else if (in_mon.elem_row != 2'd3) begin
        proj_store[in_mon.which_matrix*12 + in_mon.elem_row*4 + in_mon.elem_col]
          = in_mon.elem_value;
      end
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (entry_q.size() == 0) begin
        report("unexpected beat", 64'(out_mon.out_value), 64'd0);
      end else begin
        want = entry_q.pop_front();
        if (out_mon.out_row !== want.row) report("row", 64'(out_mon.out_row), 64'(want.row));
        if (out_mon.out_col !== want.col) report("col", 64'(out_mon.out_col), 64'(want.col));
        if (out_mon.out_value !== want.value)
          report("value", 64'(out_mon.out_value), 64'(want.value));
        if (out_mon.saturated !== want.sat)
          report("saturated", 64'(out_mon.saturated), 64'(want.sat));
        if (out_mon.last !== want.last) report("last", 64'(out_mon.last), 64'(want.last));
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Loads projection pairs and issues compute commands with bursty input and
// a stalling receiver; the checker predicts and compares every entry.
// ----------------------------------------------------------------------------
module tb;
  import ffp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_entries;
  int   burst_left = 0;

  ffp_in_if  in_ch ();
  ffp_out_if out_ch ();

  fundamental_from_projections dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  ffp_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                         .fail_count(fail_count), .pending_entries(pending_entries));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.which_matrix = 1'b0;
    in_ch.elem_row = 2'd0;
    in_ch.elem_col = 2'd0;
    in_ch.elem_value = 16'sd0;
    out_ch.ready = 1'b0;
  end

  // Receiver stall pattern: long ready stretches, sometimes choppy.
  always @(posedge clk) begin
    int mode;
    mode = ($urandom_range(0, 63) < 8) ? 1 : 0;
    out_ch.ready <= mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  // Send one beat: bursts of random length with random gaps between.
  task automatic send_beat(input logic op, input logic wm, input logic [1:0] r,
                           input logic [1:0] c, input logic signed [15:0] v);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.which_matrix <= wm;
    in_ch.elem_row <= r;
    in_ch.elem_col <= c;
    in_ch.elem_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value(input int mode);
    case (mode)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  // Fill all 24 entries in random order.
  task automatic load_pair(input int mode);
    int order [24];
    int k, t, s;
    for (k = 0; k < 24; k++) order[k] = k;
    for (k = 23; k > 0; k--) begin
      s = $urandom_range(0, k);
      t = order[k]; order[k] = order[s]; order[s] = t;
    end
    for (k = 0; k < 24; k++)
      send_beat(OP_LOAD, 1'(order[k] / 12), 2'((order[k] % 12) / 4), 2'(order[k] % 4),
                pick_value(mode));
  endtask

  initial begin
    int idx;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: max, min, row-3 ignored loads, compute with junk fields.
    load_pair(0);
    send_beat(OP_COMPUTE, 1'b1, 2'd3, 2'd3, 16'sh5A5A);
    load_pair(1);
    send_beat(OP_LOAD, 1'b0, 2'd3, 2'd2, 16'sh1234);
    send_beat(OP_LOAD, 1'b1, 2'd3, 2'd1, 16'shEDCB);
    send_beat(OP_COMPUTE, 1'b0, 2'd0, 2'd0, 16'sh0000);

    // Hold off until every entry is back.
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_entries != 0) @(posedge clk);

    // Random: full reloads, partial updates, stray row-3 loads, computes.
    for (int n = 0; n < 5; n++) begin
      load_pair($urandom_range(0, 3));
      send_beat(OP_COMPUTE, 1'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 4) == 0)
          send_beat(OP_LOAD, 1'($urandom), 2'd3, 2'($urandom), 16'($urandom));
        else begin
          idx = $urandom_range(0, 23);
          send_beat(OP_LOAD, 1'(idx / 12), 2'((idx % 12) / 4), 2'(idx % 4), pick_value(3));
        end
      end
      send_beat(OP_COMPUTE, 1'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_entries != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule
